/* src/tqdp_pkg.sv */
// Package for the ternary packed dot product block.
// Word types, accumulator widths, saturation limits and the digit extraction function.
// No dependencies.
package tqdp_pkg;

    localparam int BACC_W  = 25;
    localparam int RACC_W  = 48;
    localparam int ACT_W   = 16;
    localparam int SCALE_W = 16;
    localparam int RES_W   = 32;

    localparam int MUL_A_W = BACC_W;
    localparam int MUL_B_W = SCALE_W + 1;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;

    localparam int RACC_HALF = RACC_W / 2;

    localparam logic signed [BACC_W-1:0] BACC_MAX = {1'b0, {(BACC_W-1){1'b1}}};
    localparam logic signed [BACC_W-1:0] BACC_MIN = {1'b1, {(BACC_W-1){1'b0}}};
    localparam logic signed [RACC_W-1:0] RACC_MAX = {1'b0, {(RACC_W-1){1'b1}}};
    localparam logic signed [RACC_W-1:0] RACC_MIN = {1'b1, {(RACC_W-1){1'b0}}};
    localparam logic signed [63:0] RES_MAX64 = 64'sd2147483647;
    localparam logic signed [63:0] RES_MIN64 = -64'sd2147483648;
    localparam logic signed [RES_W-1:0] RES_MAX = {1'b0, {(RES_W-1){1'b1}}};
    localparam logic signed [RES_W-1:0] RES_MIN = {1'b1, {(RES_W-1){1'b0}}};

    localparam logic signed [SCALE_W-1:0] TSCALE_RESET = 16'sh7FFF;

    // digit codes
    localparam logic [1:0] TRIT_NEG  = 2'd0;
    localparam logic [1:0] TRIT_ZERO = 2'd1;
    localparam logic [1:0] TRIT_POS  = 2'd2;

    localparam logic [7:0] POW3_MOD256 [8] = '{8'd1, 8'd3, 8'd9, 8'd27, 8'd81,
                                               8'd243, 8'd217, 8'd139};

    typedef struct packed {
        logic [7:0]                packed_byte;
        logic [2:0]                trit_pos;
        logic signed [ACT_W-1:0]   activation;
        logic signed [SCALE_W-1:0] block_scale;
        logic                      last_of_block;
        logic                      last_of_row;
    } in_word_t;

    typedef struct packed {
        logic signed [RES_W-1:0] row_result;
        logic                    saturated;
    } out_word_t;

    // digit = ((byte * 3^pos mod 256) * 3) >> 8
    function automatic logic [1:0] trit_of(input logic [7:0] b, input logic [2:0] pos);
        logic [15:0] prod;
        logic [7:0]  q;
        logic [9:0]  q3;
        begin
            prod = b * POW3_MOD256[pos];
            q    = prod[7:0];
            q3   = {2'b00, q} + {1'b0, q, 1'b0};
            return q3[9:8];
        end
    endfunction

endpackage

/* src/tqdp_mul.sv */
// Shared signed multiplier of the ternary dot product datapath.
// Serves block scaling and both halves of the row scaling. Depends on tqdp_pkg.
module tqdp_mul
    import tqdp_pkg::*;
(
    input  logic signed [MUL_A_W-1:0] a,
    input  logic signed [MUL_B_W-1:0] b,
    output logic signed [MUL_P_W-1:0] p
);

    assign p = MUL_P_W'(a) * MUL_P_W'(b);

endmodule

/* src/ternary_packed_dot_product.sv */
// Top level of the ternary packed dot product block: sequencer and datapath.
// Depends on tqdp_pkg and tqdp_mul.
//
// Usage:
//   item_* carries one weight word (packed byte, digit position, activation,
//   block scale, block/row end marks). A word is taken when item_valid is
//   high and item_stall is low. result_* carries one row result word per
//   word with last_of_row set; the receiver holds it with result_stall.
//   cfg_we/cfg_wdata write the tensor scale; write it only while idle.
// Timing:
//   Plain words can follow back to back.
//   A block end steps through block scale multiply, then row add.
//   A row end runs the block fold, then the row scale as two 24-bit
//   partial products through the one shared multiplier, then combine,
//   floor shift and clip; the result is valid the cycle after that.
//   item_stall is high while the sequencer is busy.
// Stall: the result sits in an output register, so a stalled receiver only
//   blocks the next row end, which waits in its final step.
// Reset: accumulators clear, tensor scale returns to 32767, no result valid.
module ternary_packed_dot_product
    import tqdp_pkg::*;
#(
    parameter int SCALE_FRAC_BITS = 15
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      item_valid,
    output logic                      item_stall,
    input  in_word_t                  item_word,
    output logic                      result_valid,
    input  logic                      result_stall,
    output out_word_t                 result_word,
    input  logic                      cfg_we,
    input  logic signed [SCALE_W-1:0] cfg_wdata
);

    localparam int SHIFT = 2 * SCALE_FRAC_BITS;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_BMUL = 6'b000010,
        S_BADD = 6'b000100,
        S_RLO  = 6'b001000,
        S_RHI  = 6'b010000,
        S_FIN  = 6'b100000
    } state_t;

    state_t                      state_reg, state_next;
    logic signed [BACC_W-1:0]    block_acc_reg, block_acc_next;
    logic signed [RACC_W-1:0]    row_acc_reg, row_acc_next;
    logic signed [SCALE_W-1:0]   tscale_reg, tscale_next;
    logic                        result_valid_reg, result_valid_next;
    logic signed [SCALE_W-1:0]   bscale_reg, bscale_next;
    logic                        last_row_reg, last_row_next;
    logic signed [MUL_P_W-1:0]   product_reg, product_next;
    logic signed [MUL_P_W-1:0]   plo_reg, plo_next;
    out_word_t                   result_word_reg, result_word_next;

    logic signed [MUL_A_W-1:0]   mul_a;
    logic signed [MUL_B_W-1:0]   mul_b;
    logic signed [MUL_P_W-1:0]   mul_p;

    logic                        accept;
    logic                        out_free;
    logic [1:0]                  trit;
    logic signed [BACC_W:0]      bsum;
    logic signed [BACC_W-1:0]    bsat;
    logic signed [RACC_W:0]      rsum;
    logic signed [RACC_W-1:0]    rsat;
    logic signed [63:0]          full_prod;
    logic signed [63:0]          scaled;

    tqdp_mul u_mul (
        .a (mul_a),
        .b (mul_b),
        .p (mul_p)
    );

    assign item_stall   = (state_reg != S_IDLE);
    assign accept       = item_valid && !item_stall;
    assign out_free     = !result_valid_reg || !result_stall;
    assign result_valid = result_valid_reg;
    assign result_word  = result_word_reg;

    always_comb
    begin
        unique case (state_reg)
            S_RLO:
            begin
                mul_a = signed'({1'b0, row_acc_reg[RACC_HALF-1:0]});
                mul_b = signed'({tscale_reg[SCALE_W-1], tscale_reg});
            end
            S_RHI:
            begin
                mul_a = signed'({row_acc_reg[RACC_W-1], row_acc_reg[RACC_W-1:RACC_HALF]});
                mul_b = signed'({tscale_reg[SCALE_W-1], tscale_reg});
            end
            default:
            begin
                mul_a = block_acc_reg;
                mul_b = signed'({bscale_reg[SCALE_W-1], bscale_reg});
            end
        endcase
    end

    always_comb
    begin
        trit = trit_of(item_word.packed_byte, item_word.trit_pos);
        unique case (trit)
            TRIT_POS: bsum = (BACC_W+1)'(block_acc_reg) + (BACC_W+1)'(item_word.activation);
            TRIT_NEG: bsum = (BACC_W+1)'(block_acc_reg) - (BACC_W+1)'(item_word.activation);
            default:  bsum = (BACC_W+1)'(block_acc_reg);
        endcase
        if (bsum[BACC_W] != bsum[BACC_W-1])
            bsat = bsum[BACC_W] ? BACC_MIN : BACC_MAX;
        else
            bsat = bsum[BACC_W-1:0];

        rsum = (RACC_W+1)'(row_acc_reg) + (RACC_W+1)'(product_reg);
        if (rsum[RACC_W] != rsum[RACC_W-1])
            rsat = rsum[RACC_W] ? RACC_MIN : RACC_MAX;
        else
            rsat = rsum[RACC_W-1:0];

        full_prod = (64'(product_reg) <<< RACC_HALF) + 64'(plo_reg);
        scaled    = full_prod >>> SHIFT;
    end

    always_comb
    begin
        state_next        = state_reg;
        block_acc_next    = block_acc_reg;
        row_acc_next      = row_acc_reg;
        tscale_next       = cfg_we ? cfg_wdata : tscale_reg;
        result_valid_next = result_valid_reg && result_stall;
        bscale_next       = bscale_reg;
        last_row_next     = last_row_reg;
        product_next      = product_reg;
        plo_next          = plo_reg;
        result_word_next  = result_word_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    block_acc_next = bsat;
                    bscale_next    = item_word.block_scale;
                    last_row_next  = item_word.last_of_row;
                    if (item_word.last_of_block || item_word.last_of_row)
                        state_next = S_BMUL;
                end
            end
            S_BMUL:
            begin
                product_next   = mul_p;
                block_acc_next = '0;
                state_next     = S_BADD;
            end
            S_BADD:
            begin
                row_acc_next = rsat;
                state_next   = last_row_reg ? S_RLO : S_IDLE;
            end
            S_RLO:
            begin
                product_next = mul_p;
                state_next   = S_RHI;
            end
            S_RHI:
            begin
                plo_next     = product_reg;
                product_next = mul_p;
                state_next   = S_FIN;
            end
            S_FIN:
            begin
                if (out_free)
                begin
                    if (scaled > RES_MAX64)
                    begin
                        result_word_next.row_result = RES_MAX;
                        result_word_next.saturated  = 1'b1;
                    end
                    else if (scaled < RES_MIN64)
                    begin
                        result_word_next.row_result = RES_MIN;
                        result_word_next.saturated  = 1'b1;
                    end
                    else
                    begin
                        result_word_next.row_result = scaled[RES_W-1:0];
                        result_word_next.saturated  = 1'b0;
                    end
                    result_valid_next = 1'b1;
                    row_acc_next      = '0;
                    state_next        = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            block_acc_reg    <= '0;
            row_acc_reg      <= '0;
            tscale_reg       <= TSCALE_RESET;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            block_acc_reg    <= block_acc_next;
            row_acc_reg      <= row_acc_next;
            tscale_reg       <= tscale_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bscale_reg      <= bscale_next;
        last_row_reg    <= last_row_next;
        product_reg     <= product_next;
        plo_reg         <= plo_next;
        result_word_reg <= result_word_next;
    end

    a_result_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid_reg) |-> $past(state_reg == S_FIN))
        else $error("result appeared outside final step");

    a_block_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_BMUL |=> block_acc_reg == '0 && state_reg == S_BADD)
        else $error("block accumulator not cleared after fold");

    a_row_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FIN && out_free) |=>
            row_acc_reg == '0 && state_reg == S_IDLE && result_valid_reg)
        else $error("row end did not emit and clear");

endmodule

/* verif/testbench.sv */
// Self-checking testbench for ternary_packed_dot_product: random and directed weight words,
// a scoreboard class that predicts the row results, and a randomly stalling result receiver.
// Depends on tqdp_pkg and the block's RTL.
module testbench;
    import tqdp_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int FRAC_BITS   = 15;
    localparam int CYCLE_LIMIT = 2000000;
    localparam int LONG_BLOCKS = 1;
    localparam int LONG_LEN    = 520;
    localparam int HOLD_CYCLES = 400;

    class row_scoreboard;
        longint    blk_sum;
        longint    row_sum;
        longint    tscale;
        out_word_t expected_q[$];
        int        errors;

        function new();
            blk_sum = 0;
            row_sum = 0;
            tscale  = TSCALE_RESET;
            errors  = 0;
        endfunction

        function void set_scale(input logic signed [SCALE_W-1:0] v);
            tscale = v;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function longint clip(input longint v, input longint lo, input longint hi);
            if (v < lo)
                return lo;
            if (v > hi)
                return hi;
            return v;
        endfunction

        task report(input string msg);
            $display("mismatch at %0t: %s", $realtime, msg);
            errors++;
        endtask

        // update running sums for one accepted word; queue a row result on row end
        function void note_word(input in_word_t w);
            int        mult;
            int        q;
            logic [1:0] digit;
            longint    act;
            longint    v;
            out_word_t e;
            mult = 1;
            repeat (w.trit_pos)
                mult = (mult * 3) % 256;
            q     = (w.packed_byte * mult) % 256;
            digit = 2'((q * 3) >> 8);
            act   = w.activation;
            if (digit == TRIT_POS)
                blk_sum = clip(blk_sum + act, BACC_MIN, BACC_MAX);
            else if (digit == TRIT_NEG)
                blk_sum = clip(blk_sum - act, BACC_MIN, BACC_MAX);
            if (w.last_of_block || w.last_of_row)
            begin
                row_sum = clip(row_sum + blk_sum * longint'(w.block_scale), RACC_MIN, RACC_MAX);
                blk_sum = 0;
            end
            if (w.last_of_row)
            begin
                v = (row_sum * tscale) >>> (2 * FRAC_BITS);
                e.saturated = 1'b0;
                if (v > RES_MAX64)
                begin
                    v = RES_MAX64;
                    e.saturated = 1'b1;
                end
                if (v < RES_MIN64)
                begin
                    v = RES_MIN64;
                    e.saturated = 1'b1;
                end
                e.row_result = 32'(v);
                expected_q.push_back(e);
                row_sum = 0;
            end
        endfunction

        task check_row(input out_word_t got);
            out_word_t e;
            if (expected_q.size() == 0)
            begin
                report($sformatf("row result %0d with none expected", got.row_result));
                return;
            end
            e = expected_q.pop_front();
            if (got.row_result !== e.row_result)
                report($sformatf("row_result %0d, expected %0d", got.row_result, e.row_result));
            if (got.saturated !== e.saturated)
                report($sformatf("saturated %0b, expected %0b (row_result %0d)",
                                 got.saturated, e.saturated, e.row_result));
        endtask
    endclass

    logic                      clk          = 1'b0;
    logic                      rst_n        = 1'b0;
    logic                      item_valid   = 1'b0;
    logic                      item_stall;
    in_word_t                  item_word    = '0;
    logic                      result_valid;
    logic                      result_stall = 1'b0;
    out_word_t                 result_word;
    logic                      cfg_we       = 1'b0;
    logic signed [SCALE_W-1:0] cfg_wdata    = '0;

    row_scoreboard rows;
    int            cycles = 0;

    ternary_packed_dot_product #(
        .SCALE_FRAC_BITS(FRAC_BITS)
    ) DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_valid  (item_valid),
        .item_stall  (item_stall),
        .item_word   (item_word),
        .result_valid(result_valid),
        .result_stall(result_stall),
        .result_word (result_word),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata)
    );

    always #2 clk = ~clk;

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("[ternary_packed_dot_product] ERROR");
            $finish;
        end
    end

    // result receiver: stall pattern picked at random from four modes, one long hold-off
    int  rows_seen  = 0;
    int  hold_left  = 0;
    bit  hold_done  = 1'b0;
    int  stall_mode = 0;
    int  mode_timer = 0;

    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
        begin
            rows.check_row(result_word);
            rows_seen++;
        end
        if (mode_timer == 0)
        begin
            stall_mode = $urandom_range(0, 3);
            mode_timer = 50;
        end
        mode_timer--;
        if (hold_left > 0)
        begin
            hold_left--;
            result_stall <= 1'b1;
        end
        else if (!hold_done && rows_seen >= 8)
        begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
            result_stall <= 1'b1;
        end
        else
        begin
            case (stall_mode)
                0: result_stall <= 1'b0;
                1: result_stall <= ($urandom_range(0, 1) == 0);
                2: result_stall <= (cycles % 3 == 0);
                default: result_stall <= ($urandom_range(0, 4) != 0);
            endcase
        end
    end

    function automatic in_word_t mk(input logic [7:0] b, input logic [2:0] p,
                                    input logic signed [15:0] a, input logic signed [15:0] s,
                                    input logic lb, input logic lr);
        in_word_t w;
        w.packed_byte   = b;
        w.trit_pos      = p;
        w.activation    = a;
        w.block_scale   = s;
        w.last_of_block = lb;
        w.last_of_row   = lr;
        return w;
    endfunction

    function automatic logic signed [15:0] pick16();
        case ($urandom_range(0, 9))
            0: return 16'sh7FFF;
            1: return 16'sh8000;
            2: return 16'($urandom_range(0, 15)) - 16'sd8;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic add_directed(ref in_word_t q[$]);
        q.push_back(mk(8'd0,   3'd0, 16'sh7FFF, 16'sh0000, 1'b0, 1'b0));
        q.push_back(mk(8'd255, 3'd0, 16'sh8000, 16'sh0000, 1'b0, 1'b0));
        q.push_back(mk(8'd86,  3'd0, 16'sh1234, 16'sh0000, 1'b0, 1'b0));
        q.push_back(mk(8'd171, 3'd1, 16'sh0100, 16'sh0000, 1'b0, 1'b0));
        q.push_back(mk(8'd29,  3'd2, 16'shF00F, 16'sh0000, 1'b0, 1'b0));
        q.push_back(mk(8'd200, 3'd3, 16'sh0777, 16'sh0000, 1'b0, 1'b0));
        q.push_back(mk(8'd13,  3'd4, 16'sh8001, 16'sh7FFF, 1'b1, 1'b0));
        // digit positions past five wrap the multiplier
        q.push_back(mk(8'd255, 3'd5, 16'sh2345, 16'sh0000, 1'b0, 1'b0));
        q.push_back(mk(8'd128, 3'd6, 16'shC000, 16'sh0000, 1'b0, 1'b0));
        q.push_back(mk(8'd77,  3'd7, 16'sh7FFF, 16'sh8000, 1'b1, 1'b0));
        q.push_back(mk(8'd255, 3'd7, 16'sh4000, 16'sh0000, 1'b1, 1'b0));
        // row end without block end folds the partial block
        q.push_back(mk(8'd255, 3'd0, 16'sh7FFF, 16'sh4000, 1'b0, 1'b1));
        // floor rounding of a small negative row
        q.push_back(mk(8'd255, 3'd0, 16'shFFFF, 16'sh0001, 1'b1, 1'b1));
        q.push_back(mk(8'd255, 3'd0, 16'sh8000, 16'sh8000, 1'b1, 1'b1));
        q.push_back(mk(8'd0,   3'd0, 16'sh8000, 16'sh7FFF, 1'b1, 1'b1));
        q.push_back(mk(8'd0,   3'd3, 16'sh0001, 16'sh0001, 1'b0, 1'b1));
        q.push_back(mk(8'd170, 3'd0, 16'sh7FFF, 16'sh7FFF, 1'b0, 1'b0));
        q.push_back(mk(8'd171, 3'd0, 16'sh7FFF, 16'sh7FFF, 1'b1, 1'b0));
        q.push_back(mk(8'd85,  3'd0, 16'sh7FFF, 16'sh8000, 1'b1, 1'b0));
        q.push_back(mk(8'd255, 3'd2, 16'sh5555, 16'shAAAA, 1'b1, 1'b1));
    endtask

    // one block long enough to clip the block sum
    task automatic add_long_row(ref in_word_t q[$], input logic signed [15:0] bscale);
        in_word_t w;
        bit       lb;
        for (int b = 0; b < LONG_BLOCKS; b++)
        begin
            for (int i = 0; i < LONG_LEN; i++)
            begin
                lb = (i == LONG_LEN - 1);
                if ($urandom_range(0, 1))
                    w = mk(8'd255, 3'd0, 16'sh7FFF, 16'($urandom), lb, 1'b0);
                else
                    w = mk(8'd0, 3'($urandom_range(0, 7)), 16'sh8000, 16'($urandom), lb, 1'b0);
                if (lb)
                    w.block_scale = bscale;
                w.last_of_row = lb && (b == LONG_BLOCKS - 1);
                q.push_back(w);
            end
        end
    endtask

    task automatic add_random_rows(ref in_word_t q[$], input int n);
        in_word_t w;
        int       count;
        int       nb;
        int       len;
        count = 0;
        while (count < n)
        begin
            nb = $urandom_range(1, 3);
            for (int b = 0; b < nb; b++)
            begin
                len = $urandom_range(1, 12);
                for (int i = 0; i < len; i++)
                begin
                    w = mk(8'($urandom), 3'($urandom_range(0, 7)), pick16(), pick16(),
                           i == len - 1, (b == nb - 1) && (i == len - 1));
                    if ($urandom_range(0, 15) == 0)
                    begin
                        w.last_of_block = 1'($urandom);
                        w.last_of_row   = ($urandom_range(0, 3) == 0);
                    end
                    q.push_back(w);
                    count++;
                end
            end
        end
        q[q.size()-1].last_of_row = 1'b1;
    endtask

    task automatic send_word(input in_word_t w);
        item_valid <= 1'b1;
        item_word  <= w;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        rows.note_word(w);
    endtask

    task automatic send_queue(ref in_word_t q[$], input bit use_gaps);
        int burst_left;
        burst_left = $urandom_range(1, 32);
        foreach (q[i])
        begin
            if (use_gaps && burst_left == 0)
            begin
                item_valid <= 1'b0;
                repeat ($urandom_range(1, 6))
                    @(posedge clk);
                burst_left = $urandom_range(1, 32);
            end
            send_word(q[i]);
            burst_left--;
        end
        item_valid <= 1'b0;
    endtask

    task automatic drain();
        while (rows.pending() > 0)
            @(posedge clk);
        repeat (12)
            @(posedge clk);
    endtask

    task automatic write_scale(input logic signed [SCALE_W-1:0] v);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we    <= 1'b0;
        rows.set_scale(v);
    endtask

    initial
    begin
        in_word_t                  stim_q[$];
        logic signed [SCALE_W-1:0] scales[7];
        rows = new();
        scales = '{16'sh7FFF, 16'sh8000, 16'sh0000, 16'sh0001, 16'shFFFF,
                   16'($urandom), 16'($urandom)};
        repeat (8)
            @(posedge clk);
        rst_n <= 1'b1;
        repeat (4)
            @(posedge clk);
        for (int ph = 0; ph < 7; ph++)
        begin
            write_scale(scales[ph]);
            stim_q.delete();
            if (ph == 0)
                add_directed(stim_q);
            add_random_rows(stim_q, (ph == 5) ? 40 : 25);
            send_queue(stim_q, ph != 6);
            if (ph == 1)
            begin
                stim_q.delete();
                add_long_row(stim_q, 16'sh7FFF);
                send_queue(stim_q, 1'b0);
            end
            drain();
        end
        if (rows.errors == 0 && rows.pending() == 0)
            $display("[ternary_packed_dot_product] OK");
        else
            $display("[ternary_packed_dot_product] ERROR");
        $finish;
    end

endmodule
